// File: sv/cpcc_pkg.sv
// Package with shared widths, codes and the multiply step program of the plane check.
package cpcc_pkg;

   localparam int COORD_W    = 24;
   localparam int COORD_BITS = 24;
   localparam int SPACING_W  = 23;
   localparam int E_W        = COORD_BITS + 1;
   localparam int N_W        = 2 * E_W + 2;
   localparam int D_W        = N_W + E_W + 2;
   localparam int NN_W       = 2 * N_W + 1;
   localparam int SQ_W       = 2 * SPACING_W + 1;
   localparam int ACC_W      = 2 * D_W;
   localparam int B_W        = D_W;
   localparam int CMP_W      = ACC_W + 4;
   localparam int STEP_W     = 5;
   localparam int CNT_W      = 7;

   localparam logic [SPACING_W-1:0] SPACING_RESET = SPACING_W'(256);
   localparam logic [SPACING_W-1:0] SEED_LIMIT    = SPACING_W'(5120000);

   localparam logic [CNT_W-1:0] LEN_E  = CNT_W'(E_W);
   localparam logic [CNT_W-1:0] LEN_N  = CNT_W'(N_W);
   localparam logic [CNT_W-1:0] LEN_D  = CNT_W'(D_W);
   localparam logic [CNT_W-1:0] LEN_S  = CNT_W'(SPACING_W + 1);
   localparam logic [CNT_W-1:0] LEN_SQ = CNT_W'(SQ_W);

   localparam logic [STEP_W-1:0] STEP_ANGLE = STEP_W'(0);
   localparam logic [STEP_W-1:0] STEP_CROSS = STEP_W'(11);
   localparam logic [STEP_W-1:0] STEP_CAND  = STEP_W'(17);

   typedef enum logic [0:0] {
      CSR_MAX_SPACING = 1'b0,
      CSR_MIN_SPACING = 1'b1
   } csr_idx_type;

   typedef enum logic [4:0] {
      SRC_E1X, SRC_E1Y, SRC_E1Z, SRC_E2X, SRC_E2Y, SRC_E2Z,
      SRC_VX, SRC_VY, SRC_VZ, SRC_NX, SRC_NY, SRC_NZ,
      SRC_DOT, SRC_N1, SRC_N2, SRC_DD, SRC_NN,
      SRC_MAX, SRC_MIN, SRC_MAXSQ, SRC_MINSQ
   } src_type;

   typedef enum logic [3:0] {
      DST_NONE, DST_N1, DST_N2, DST_DOT, DST_LHS, DST_RHI, DST_RLO,
      DST_NX, DST_NY, DST_NZ, DST_DD, DST_NN, DST_MAXSQ, DST_MINSQ
   } dst_type;

   typedef struct packed {
      src_type              a;
      src_type              b;
      logic [CNT_W-1:0]     len;
      logic                 clr;
      logic                 neg;
      dst_type              dst;
      logic                 last;
   } step_type;

   typedef enum logic [2:0] {
      DP_NOP, DP_ORIGIN, DP_EDGE1, DP_EDGE2, DP_VEC, DP_FLAGS, DP_EMIT
   } dp_op_type;

   typedef struct packed {
      logic                 capture;
      dp_op_type            op;
      logic                 start;
      logic [STEP_W-1:0]    step;
   } dp_cmd_type;

   typedef struct packed {
      logic item_cmd;
      logic item_last;
      logic busy;
      logic angle_pass;
      logic degenerate;
      logic out_busy;
   } dp_stat_type;

   function automatic step_type mk(input src_type a, input src_type b,
                                   input logic [CNT_W-1:0] len, input logic clr,
                                   input logic neg, input dst_type dst, input logic last);
      step_type s;
      s.a = a; s.b = b; s.len = len; s.clr = clr; s.neg = neg; s.dst = dst; s.last = last;
      return s;
   endfunction

   // Each entry is one signed product added to (or taken from) the accumulator.
   function automatic step_type step_rom(input logic [STEP_W-1:0] idx);
      step_type s;
      case (idx)
         5'd0:  s = mk(SRC_E1X, SRC_E1X, LEN_E, 1'b1, 1'b0, DST_NONE, 1'b0);
         5'd1:  s = mk(SRC_E1Y, SRC_E1Y, LEN_E, 1'b0, 1'b0, DST_NONE, 1'b0);
         5'd2:  s = mk(SRC_E1Z, SRC_E1Z, LEN_E, 1'b0, 1'b0, DST_N1, 1'b0);
         5'd3:  s = mk(SRC_E2X, SRC_E2X, LEN_E, 1'b1, 1'b0, DST_NONE, 1'b0);
         5'd4:  s = mk(SRC_E2Y, SRC_E2Y, LEN_E, 1'b0, 1'b0, DST_NONE, 1'b0);
         5'd5:  s = mk(SRC_E2Z, SRC_E2Z, LEN_E, 1'b0, 1'b0, DST_N2, 1'b0);
         5'd6:  s = mk(SRC_E1X, SRC_E2X, LEN_E, 1'b1, 1'b0, DST_NONE, 1'b0);
         5'd7:  s = mk(SRC_E1Y, SRC_E2Y, LEN_E, 1'b0, 1'b0, DST_NONE, 1'b0);
         5'd8:  s = mk(SRC_E1Z, SRC_E2Z, LEN_E, 1'b0, 1'b0, DST_DOT, 1'b0);
         5'd9:  s = mk(SRC_DOT, SRC_DOT, LEN_N, 1'b1, 1'b0, DST_LHS, 1'b0);
         5'd10: s = mk(SRC_N1,  SRC_N2,  LEN_N, 1'b1, 1'b0, DST_RHI, 1'b1);
         5'd11: s = mk(SRC_E1Y, SRC_E2Z, LEN_E, 1'b1, 1'b0, DST_NONE, 1'b0);
         5'd12: s = mk(SRC_E1Z, SRC_E2Y, LEN_E, 1'b0, 1'b1, DST_NX, 1'b0);
         5'd13: s = mk(SRC_E1Z, SRC_E2X, LEN_E, 1'b1, 1'b0, DST_NONE, 1'b0);
         5'd14: s = mk(SRC_E1X, SRC_E2Z, LEN_E, 1'b0, 1'b1, DST_NY, 1'b0);
         5'd15: s = mk(SRC_E1X, SRC_E2Y, LEN_E, 1'b1, 1'b0, DST_NONE, 1'b0);
         5'd16: s = mk(SRC_E1Y, SRC_E2X, LEN_E, 1'b0, 1'b1, DST_NZ, 1'b1);
         5'd17: s = mk(SRC_NX, SRC_VX, LEN_E, 1'b1, 1'b0, DST_NONE, 1'b0);
         5'd18: s = mk(SRC_NY, SRC_VY, LEN_E, 1'b0, 1'b0, DST_NONE, 1'b0);
         5'd19: s = mk(SRC_NZ, SRC_VZ, LEN_E, 1'b0, 1'b0, DST_DD, 1'b0);
         5'd20: s = mk(SRC_NX, SRC_NX, LEN_N, 1'b1, 1'b0, DST_NONE, 1'b0);
         5'd21: s = mk(SRC_NY, SRC_NY, LEN_N, 1'b0, 1'b0, DST_NONE, 1'b0);
         5'd22: s = mk(SRC_NZ, SRC_NZ, LEN_N, 1'b0, 1'b0, DST_NN, 1'b0);
         5'd23: s = mk(SRC_DD, SRC_DD, LEN_D, 1'b1, 1'b0, DST_LHS, 1'b0);
         5'd24: s = mk(SRC_MAX, SRC_MAX, LEN_S, 1'b1, 1'b0, DST_MAXSQ, 1'b0);
         5'd25: s = mk(SRC_MIN, SRC_MIN, LEN_S, 1'b1, 1'b0, DST_MINSQ, 1'b0);
         5'd26: s = mk(SRC_NN, SRC_MAXSQ, LEN_SQ, 1'b1, 1'b0, DST_RHI, 1'b0);
         5'd27: s = mk(SRC_NN, SRC_MINSQ, LEN_SQ, 1'b1, 1'b0, DST_RLO, 1'b1);
         default: s = mk(SRC_E1X, SRC_E1X, LEN_E, 1'b1, 1'b0, DST_NONE, 1'b1);
      endcase
      return s;
   endfunction

endpackage

// File: sv/cpcc_if.sv
// Valid/ready channel interfaces for point beats and result beats.
interface cpcc_req_if;
   logic                                valid;
   logic                                ready;
   logic                                cmd;
   logic signed [cpcc_pkg::COORD_W-1:0] px;
   logic signed [cpcc_pkg::COORD_W-1:0] py;
   logic signed [cpcc_pkg::COORD_W-1:0] pz;
   logic                                last_point;
   modport source(output valid, cmd, px, py, pz, last_point, input ready);
   modport sink(input valid, cmd, px, py, pz, last_point, output ready);
endinterface

interface cpcc_rsp_if;
   logic valid;
   logic ready;
   logic keep;
   logic plane_degenerate;
   modport source(output valid, keep, plane_degenerate, input ready);
   modport sink(input valid, keep, plane_degenerate, output ready);
endinterface

// File: sv/contour_plane_coincidence_check.sv
// Top level of the contour plane coincidence check.
// Point beats arrive on req_ch: cmd 0 carries reference contour points, cmd 1 candidate
// points, last_point closes a contour. The first reference point is the origin, the
// second sets edge one, and the first later point more than 30 degrees off edge one (else
// the closing reference point) sets edge two; the plane normal is their cross product.
// On the last candidate point one beat leaves on rsp_ch with keep and plane_degenerate.
// csr_we/csr_index/csr_wdata write max_spacing (index 0) and min_spacing (index 1); the user
// must write them only while the block is idle, the block itself does not enforce it.
// All products run through one shift-add multiply-accumulate unit, one multiplier bit
// per cycle, so an item's cost follows the sum of its product widths: an origin or
// first-edge point runs no product, a reference point tested for edge two runs the
// angle program, the closing reference point also computes the normal, a candidate
// point runs the candidate program, a candidate on a zero normal runs none, and the
// point that emits a result also passes through the emit step.
// One beat is worked on at a time; req_ch.ready is high only between items.
// The result sits in an output register: the next item is taken while it waits, and
// only a further result stalls until rsp_ch.ready takes the pending beat.
// Reset clears the normal and the output valid, sets the flags to their start values,
// restarts the reference phase, and sets both spacings to 256.
module contour_plane_coincidence_check (
   input  logic                           clock,
   input  logic                           reset,
   cpcc_req_if.sink                       req_ch,
   cpcc_rsp_if.source                     rsp_ch,
   input  logic                           csr_we,
   input  logic [0:0]                     csr_index,
   input  logic [cpcc_pkg::SPACING_W-1:0] csr_wdata
);

   cpcc_pkg::dp_cmd_type  cmd;
   cpcc_pkg::dp_stat_type stat;
   logic                  ready;

   assign req_ch.ready = ready;

   cpcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cpcc_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_cmd        (req_ch.cmd),
      .req_px         (req_ch.px),
      .req_py         (req_ch.py),
      .req_pz         (req_ch.pz),
      .req_last_point (req_ch.last_point),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp            (rsp_ch)
   );

   // No new point is taken while the multiply unit still works on the previous one.
   a_idle_not_busy: assert property (@(posedge clock) disable iff (reset)
      ready |-> !stat.busy) else $error("point accepted while multiplier busy");

   // A product is only launched on an idle multiply unit.
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !stat.busy) else $error("multiply started while busy");

   // A result beat appears only after the controller asked for one.
   a_emit_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(cmd.op == cpcc_pkg::DP_EMIT))
      else $error("result beat without emit command");

endmodule

// File: sv/cpcc_dpath.sv
// Datapath: geometry registers, shift-add multiply-accumulate unit, compares, result register.
module cpcc_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  cpcc_pkg::dp_cmd_type                cmd,
   output cpcc_pkg::dp_stat_type               stat,
   input  logic                                req_cmd,
   input  logic signed [cpcc_pkg::COORD_W-1:0] req_px,
   input  logic signed [cpcc_pkg::COORD_W-1:0] req_py,
   input  logic signed [cpcc_pkg::COORD_W-1:0] req_pz,
   input  logic                                req_last_point,
   input  logic                                csr_we,
   input  logic [0:0]                          csr_index,
   input  logic [cpcc_pkg::SPACING_W-1:0]      csr_wdata,
   cpcc_rsp_if.source                          rsp
);

   logic [cpcc_pkg::SPACING_W-1:0]        max_ff, max_in, min_ff, min_in;
   logic                                  it_cmd_ff, it_cmd_in, it_last_ff, it_last_in;
   logic signed [cpcc_pkg::COORD_BITS-1:0] p_ff [3];
   logic signed [cpcc_pkg::COORD_BITS-1:0] p_in [3];
   logic signed [cpcc_pkg::COORD_BITS-1:0] origin_ff [3];
   logic signed [cpcc_pkg::COORD_BITS-1:0] origin_in [3];
   logic signed [cpcc_pkg::E_W-1:0]       e1_ff [3];
   logic signed [cpcc_pkg::E_W-1:0]       e1_in [3];
   logic signed [cpcc_pkg::E_W-1:0]       e2_ff [3];
   logic signed [cpcc_pkg::E_W-1:0]       e2_in [3];
   logic signed [cpcc_pkg::E_W-1:0]       v_ff [3];
   logic signed [cpcc_pkg::E_W-1:0]       v_in [3];
   logic signed [cpcc_pkg::N_W-1:0]       n_ff [3];
   logic signed [cpcc_pkg::N_W-1:0]       n_in [3];
   logic signed [cpcc_pkg::N_W-1:0]       dot_ff, dot_in, n1_ff, n1_in, n2_ff, n2_in;
   logic signed [cpcc_pkg::D_W-1:0]       dd_ff, dd_in;
   logic signed [cpcc_pkg::NN_W-1:0]      nn_ff, nn_in;
   logic signed [cpcc_pkg::SQ_W-1:0]      maxsq_ff, maxsq_in, minsq_ff, minsq_in;
   logic [cpcc_pkg::ACC_W-1:0]            lhs_ff, lhs_in, rhi_ff, rhi_in, rlo_ff, rlo_in;
   logic [cpcc_pkg::ACC_W-1:0]            acc_ff, acc_in, a_ff, a_in, acc_next, term;
   logic [cpcc_pkg::B_W-1:0]              b_ff, b_in;
   logic [cpcc_pkg::CNT_W-1:0]            cnt_ff, cnt_in, len_ff, len_in;
   logic                                  neg_ff, neg_in, busy_ff, busy_in, mac_last;
   cpcc_pkg::dst_type                     dst_ff, dst_in;
   logic                                  abu_ff, abu_in, abl_ff, abl_in;
   logic                                  ov_ff, ov_in, keep_ff, keep_in, degen_ff, degen_in;
   cpcc_pkg::step_type                    ent;
   logic [cpcc_pkg::ACC_W-1:0]            src_a, src_b;
   logic [cpcc_pkg::CMP_W-1:0]            lhs4, rhi3, rhi9, rlo1;
   logic                                  degenerate, below_upper, below_lower;

   assign ent = cpcc_pkg::step_rom(cmd.step);

   function automatic logic [cpcc_pkg::ACC_W-1:0] pick(input cpcc_pkg::src_type s,
         input logic signed [cpcc_pkg::E_W-1:0] e1 [3], input logic signed [cpcc_pkg::E_W-1:0] e2 [3],
         input logic signed [cpcc_pkg::E_W-1:0] v [3], input logic signed [cpcc_pkg::N_W-1:0] n [3],
         input logic signed [cpcc_pkg::N_W-1:0] dt, input logic signed [cpcc_pkg::N_W-1:0] q1,
         input logic signed [cpcc_pkg::N_W-1:0] q2, input logic signed [cpcc_pkg::D_W-1:0] dd,
         input logic signed [cpcc_pkg::NN_W-1:0] nn, input logic [cpcc_pkg::SPACING_W-1:0] mx,
         input logic [cpcc_pkg::SPACING_W-1:0] mn, input logic signed [cpcc_pkg::SQ_W-1:0] mxs,
         input logic signed [cpcc_pkg::SQ_W-1:0] mns);
      logic [cpcc_pkg::ACC_W-1:0] r;
      case (s)
         cpcc_pkg::SRC_E1X:   r = cpcc_pkg::ACC_W'(e1[0]);
         cpcc_pkg::SRC_E1Y:   r = cpcc_pkg::ACC_W'(e1[1]);
         cpcc_pkg::SRC_E1Z:   r = cpcc_pkg::ACC_W'(e1[2]);
         cpcc_pkg::SRC_E2X:   r = cpcc_pkg::ACC_W'(e2[0]);
         cpcc_pkg::SRC_E2Y:   r = cpcc_pkg::ACC_W'(e2[1]);
         cpcc_pkg::SRC_E2Z:   r = cpcc_pkg::ACC_W'(e2[2]);
         cpcc_pkg::SRC_VX:    r = cpcc_pkg::ACC_W'(v[0]);
         cpcc_pkg::SRC_VY:    r = cpcc_pkg::ACC_W'(v[1]);
         cpcc_pkg::SRC_VZ:    r = cpcc_pkg::ACC_W'(v[2]);
         cpcc_pkg::SRC_NX:    r = cpcc_pkg::ACC_W'(n[0]);
         cpcc_pkg::SRC_NY:    r = cpcc_pkg::ACC_W'(n[1]);
         cpcc_pkg::SRC_NZ:    r = cpcc_pkg::ACC_W'(n[2]);
         cpcc_pkg::SRC_DOT:   r = cpcc_pkg::ACC_W'(dt);
         cpcc_pkg::SRC_N1:    r = cpcc_pkg::ACC_W'(q1);
         cpcc_pkg::SRC_N2:    r = cpcc_pkg::ACC_W'(q2);
         cpcc_pkg::SRC_DD:    r = cpcc_pkg::ACC_W'(dd);
         cpcc_pkg::SRC_NN:    r = cpcc_pkg::ACC_W'(nn);
         cpcc_pkg::SRC_MAX:   r = cpcc_pkg::ACC_W'(mx);
         cpcc_pkg::SRC_MIN:   r = cpcc_pkg::ACC_W'(mn);
         cpcc_pkg::SRC_MAXSQ: r = cpcc_pkg::ACC_W'(mxs);
         cpcc_pkg::SRC_MINSQ: r = cpcc_pkg::ACC_W'(mns);
         default:             r = '0;
      endcase
      return r;
   endfunction

   assign src_a = pick(ent.a, e1_ff, e2_ff, v_ff, n_ff, dot_ff, n1_ff, n2_ff, dd_ff, nn_ff,
                       max_ff, min_ff, maxsq_ff, minsq_ff);
   assign src_b = pick(ent.b, e1_ff, e2_ff, v_ff, n_ff, dot_ff, n1_ff, n2_ff, dd_ff, nn_ff,
                       max_ff, min_ff, maxsq_ff, minsq_ff);

   // The top multiplier bit carries negative weight, so that step subtracts (adds when negated).
   assign mac_last = (cnt_ff == (len_ff - 1'b1));
   assign term     = b_ff[0] ? a_ff : '0;
   assign acc_next = (mac_last ^ neg_ff) ? (acc_ff - term) : (acc_ff + term);

   // All compared quantities are squares, sums of squares or their products, hence nonnegative.
   assign lhs4 = cpcc_pkg::CMP_W'({lhs_ff, 2'b00});
   assign rhi3 = cpcc_pkg::CMP_W'(rhi_ff) + cpcc_pkg::CMP_W'({rhi_ff, 1'b0});
   assign rhi9 = cpcc_pkg::CMP_W'(rhi_ff) + cpcc_pkg::CMP_W'({rhi_ff, 3'b000});
   assign rlo1 = cpcc_pkg::CMP_W'(rlo_ff);

   assign degenerate  = (n_ff[0] == '0) && (n_ff[1] == '0) && (n_ff[2] == '0);
   assign below_upper = degenerate ? (max_ff != '0) : (lhs4 < rhi9);
   assign below_lower = degenerate ? (min_ff != '0) : (lhs4 < rlo1);

   always_comb begin
      max_in = max_ff;  min_in = min_ff;
      it_cmd_in = it_cmd_ff;  it_last_in = it_last_ff;
      p_in = p_ff;  origin_in = origin_ff;
      e1_in = e1_ff;  e2_in = e2_ff;  v_in = v_ff;  n_in = n_ff;
      dot_in = dot_ff;  n1_in = n1_ff;  n2_in = n2_ff;  dd_in = dd_ff;  nn_in = nn_ff;
      maxsq_in = maxsq_ff;  minsq_in = minsq_ff;
      lhs_in = lhs_ff;  rhi_in = rhi_ff;  rlo_in = rlo_ff;
      acc_in = acc_ff;  a_in = a_ff;  b_in = b_ff;  cnt_in = cnt_ff;  len_in = len_ff;
      neg_in = neg_ff;  dst_in = dst_ff;  busy_in = busy_ff;
      abu_in = abu_ff;  abl_in = abl_ff;
      ov_in = ov_ff;  keep_in = keep_ff;  degen_in = degen_ff;

      if (csr_we) begin
         case (cpcc_pkg::csr_idx_type'(csr_index))
            cpcc_pkg::CSR_MAX_SPACING: max_in = csr_wdata;
            cpcc_pkg::CSR_MIN_SPACING: min_in = csr_wdata;
            default: ;
         endcase
      end

      if (cmd.capture) begin
         it_cmd_in  = req_cmd;
         it_last_in = req_last_point;
         p_in[0] = req_px[cpcc_pkg::COORD_BITS-1:0];
         p_in[1] = req_py[cpcc_pkg::COORD_BITS-1:0];
         p_in[2] = req_pz[cpcc_pkg::COORD_BITS-1:0];
      end

      if (rsp.valid && rsp.ready) begin
         ov_in = 1'b0;
      end

      case (cmd.op)
         cpcc_pkg::DP_ORIGIN: begin
            for (int i = 0; i < 3; i++) begin
               origin_in[i] = p_ff[i];
               e1_in[i] = '0;
               e2_in[i] = '0;
               n_in[i]  = '0;
            end
         end
         cpcc_pkg::DP_EDGE1: begin
            for (int i = 0; i < 3; i++) begin
               e1_in[i] = cpcc_pkg::E_W'(p_ff[i]) - cpcc_pkg::E_W'(origin_ff[i]);
            end
         end
         cpcc_pkg::DP_EDGE2: begin
            for (int i = 0; i < 3; i++) begin
               e2_in[i] = cpcc_pkg::E_W'(p_ff[i]) - cpcc_pkg::E_W'(origin_ff[i]);
            end
         end
         cpcc_pkg::DP_VEC: begin
            for (int i = 0; i < 3; i++) begin
               v_in[i] = cpcc_pkg::E_W'(p_ff[i]) - cpcc_pkg::E_W'(origin_ff[i]);
            end
         end
         cpcc_pkg::DP_FLAGS: begin
            abu_in = abu_ff & below_upper;
            abl_in = abl_ff | below_lower;
         end
         cpcc_pkg::DP_EMIT: begin
            ov_in    = 1'b1;
            keep_in  = !(abu_ff && (abl_ff || (min_ff > cpcc_pkg::SEED_LIMIT)));
            degen_in = degenerate;
            abu_in   = 1'b1;
            abl_in   = 1'b0;
         end
         default: ;
      endcase

      if (cmd.start) begin
         acc_in  = ent.clr ? '0 : acc_ff;
         a_in    = src_a;
         b_in    = src_b[cpcc_pkg::B_W-1:0];
         cnt_in  = '0;
         len_in  = ent.len;
         neg_in  = ent.neg;
         dst_in  = ent.dst;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_next;
         a_in   = {a_ff[cpcc_pkg::ACC_W-2:0], 1'b0};
         b_in   = {1'b0, b_ff[cpcc_pkg::B_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (mac_last) begin
            busy_in = 1'b0;
            case (dst_ff)
               cpcc_pkg::DST_N1:    n1_in    = acc_next[cpcc_pkg::N_W-1:0];
               cpcc_pkg::DST_N2:    n2_in    = acc_next[cpcc_pkg::N_W-1:0];
               cpcc_pkg::DST_DOT:   dot_in   = acc_next[cpcc_pkg::N_W-1:0];
               cpcc_pkg::DST_LHS:   lhs_in   = acc_next;
               cpcc_pkg::DST_RHI:   rhi_in   = acc_next;
               cpcc_pkg::DST_RLO:   rlo_in   = acc_next;
               cpcc_pkg::DST_NX:    n_in[0]  = acc_next[cpcc_pkg::N_W-1:0];
               cpcc_pkg::DST_NY:    n_in[1]  = acc_next[cpcc_pkg::N_W-1:0];
               cpcc_pkg::DST_NZ:    n_in[2]  = acc_next[cpcc_pkg::N_W-1:0];
               cpcc_pkg::DST_DD:    dd_in    = acc_next[cpcc_pkg::D_W-1:0];
               cpcc_pkg::DST_NN:    nn_in    = acc_next[cpcc_pkg::NN_W-1:0];
               cpcc_pkg::DST_MAXSQ: maxsq_in = acc_next[cpcc_pkg::SQ_W-1:0];
               cpcc_pkg::DST_MINSQ: minsq_in = acc_next[cpcc_pkg::SQ_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      it_cmd_ff <= it_cmd_in;  it_last_ff <= it_last_in;
      p_ff <= p_in;  origin_ff <= origin_in;
      e1_ff <= e1_in;  e2_ff <= e2_in;  v_ff <= v_in;
      dot_ff <= dot_in;  n1_ff <= n1_in;  n2_ff <= n2_in;  dd_ff <= dd_in;  nn_ff <= nn_in;
      maxsq_ff <= maxsq_in;  minsq_ff <= minsq_in;
      lhs_ff <= lhs_in;  rhi_ff <= rhi_in;  rlo_ff <= rlo_in;
      acc_ff <= acc_in;  a_ff <= a_in;  b_ff <= b_in;  cnt_ff <= cnt_in;  len_ff <= len_in;
      neg_ff <= neg_in;  dst_ff <= dst_in;
      keep_ff <= keep_in;  degen_ff <= degen_in;
      if (reset) begin
         max_ff  <= cpcc_pkg::SPACING_RESET;
         min_ff  <= cpcc_pkg::SPACING_RESET;
         for (int i = 0; i < 3; i++) begin
            n_ff[i] <= '0;
         end
         busy_ff <= 1'b0;
         abu_ff  <= 1'b1;
         abl_ff  <= 1'b0;
         ov_ff   <= 1'b0;
      end else begin
         max_ff  <= max_in;
         min_ff  <= min_in;
         n_ff    <= n_in;
         busy_ff <= busy_in;
         abu_ff  <= abu_in;
         abl_ff  <= abl_in;
         ov_ff   <= ov_in;
      end
   end

   assign rsp.valid            = ov_ff;
   assign rsp.keep             = keep_ff;
   assign rsp.plane_degenerate = degen_ff;

   assign stat.item_cmd   = it_cmd_ff;
   assign stat.item_last  = it_last_ff;
   assign stat.busy       = busy_ff;
   assign stat.angle_pass = (n1_ff != '0) && (n2_ff != '0) &&
                            (dot_ff[cpcc_pkg::N_W-1] || (lhs4 < rhi3));
   assign stat.degenerate = degenerate;
   assign stat.out_busy   = ov_ff && !rsp.ready;

endmodule

// File: sv/cpcc_ctrl.sv
// Controller: reference phase tracking and sequencing of multiply programs per point beat.
module cpcc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cpcc_pkg::dp_stat_type stat,
   output cpcc_pkg::dp_cmd_type  cmd
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_DECODE = 7'b0000010,
      ST_START  = 7'b0000100,
      ST_RUN    = 7'b0001000,
      ST_LOCK   = 7'b0010000,
      ST_FLAGS  = 7'b0100000,
      ST_EMIT   = 7'b1000000
   } state_type;

   typedef enum logic [1:0] {PH_FIRST, PH_SECOND, PH_COLLECT, PH_DONE} phase_type;
   typedef enum logic [1:0] {PROG_ANGLE, PROG_CROSS, PROG_CAND} prog_type;

   state_type                   state_ff, state_in;
   phase_type                   phase_ff, phase_in;
   prog_type                    prog_ff, prog_in;
   logic                        locked_ff, locked_in;
   logic [cpcc_pkg::STEP_W-1:0] step_ff, step_in, base;
   cpcc_pkg::step_type          cur_step;

   assign cur_step = cpcc_pkg::step_rom(step_ff);

   always_comb begin
      case (prog_ff)
         PROG_ANGLE: base = cpcc_pkg::STEP_ANGLE;
         PROG_CROSS: base = cpcc_pkg::STEP_CROSS;
         PROG_CAND:  base = cpcc_pkg::STEP_CAND;
         default:    base = cpcc_pkg::STEP_ANGLE;
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      prog_in     = prog_ff;
      locked_in   = locked_ff;
      step_in     = step_ff;
      cmd.capture = 1'b0;
      cmd.op      = cpcc_pkg::DP_NOP;
      cmd.start   = 1'b0;
      cmd.step    = step_ff;
      req_ready   = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (!stat.item_cmd) begin
               state_in = ST_IDLE;
               case (phase_ff)
                  PH_SECOND: begin
                     cmd.op   = cpcc_pkg::DP_EDGE1;
                     phase_in = PH_COLLECT;
                  end
                  PH_COLLECT: begin
                     if (!locked_ff) begin
                        cmd.op   = cpcc_pkg::DP_EDGE2;
                        prog_in  = PROG_ANGLE;
                        state_in = ST_START;
                     end
                  end
                  default: begin
                     // A new reference starts: origin captured, edges and normal cleared.
                     cmd.op    = cpcc_pkg::DP_ORIGIN;
                     locked_in = 1'b0;
                     phase_in  = PH_SECOND;
                  end
               endcase
               if (stat.item_last) begin
                  phase_in = PH_DONE;
                  if (phase_ff == PH_SECOND || (phase_ff == PH_COLLECT && locked_ff)) begin
                     prog_in  = PROG_CROSS;
                     state_in = ST_START;
                  end
               end
            end else begin
               cmd.op = cpcc_pkg::DP_VEC;
               if (stat.degenerate) begin
                  state_in = ST_FLAGS;
               end else begin
                  prog_in  = PROG_CAND;
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            cmd.start = 1'b1;
            cmd.step  = base;
            step_in   = base;
            state_in  = ST_RUN;
         end
         ST_RUN: begin
            if (!stat.busy) begin
               if (cur_step.last) begin
                  case (prog_ff)
                     PROG_ANGLE: state_in = ST_LOCK;
                     PROG_CROSS: state_in = ST_IDLE;
                     default:    state_in = ST_FLAGS;
                  endcase
               end else begin
                  cmd.start = 1'b1;
                  cmd.step  = step_ff + 1'b1;
                  step_in   = step_ff + 1'b1;
               end
            end
         end
         ST_LOCK: begin
            if (stat.angle_pass) begin
               locked_in = 1'b1;
            end
            if (stat.item_last) begin
               prog_in  = PROG_CROSS;
               state_in = ST_START;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FLAGS: begin
            cmd.op   = cpcc_pkg::DP_FLAGS;
            state_in = stat.item_last ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (!stat.out_busy) begin
               cmd.op   = cpcc_pkg::DP_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      prog_ff <= prog_in;
      if (reset) begin
         state_ff  <= ST_IDLE;
         phase_ff  <= PH_FIRST;
         locked_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         locked_ff <= locked_in;
      end
   end

endmodule
